@@ rtl/dmp_pkg.sv @@
`timescale 1ns / 1ps
// dmp_pkg: shared types and constants of the diameter message parser
// record kinds, error codes and the result record; no dependencies

package dmp_pkg;

	// diameter header and avp framing
	localparam int unsigned HdrLen    = 20;
	localparam logic [7:0]  DiamVersion = 8'h01;
	localparam logic [7:0]  VendorFlag  = 8'h80;
	localparam logic [23:0] AvpFixed    = 24'd8;
	localparam logic [23:0] AvpVendHdr  = 24'd12;

	typedef enum logic [2:0] {
		REC_HEADER  = 3'd0,
		REC_AVP_HDR = 3'd1,
		REC_DATA    = 3'd2,
		REC_END     = 3'd3,
		REC_ERROR   = 3'd4
	} rec_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_VERSION   = 3'd1,
		ERR_SHORT_HDR = 3'd2,
		ERR_SHORT_MSG = 3'd3,
		ERR_AVP_HDR   = 3'd4,
		ERR_AVP_LEN   = 3'd5,
		ERR_DATA_OVR  = 3'd6
	} err_code_t;

	typedef struct packed {
		rec_kind_t   rec_kind;
		err_code_t   error_code;
		logic [23:0] msg_length;
		logic [7:0]  flag_bits;
		logic [31:0] code;
		logic [31:0] app_or_vendor;
		logic [31:0] hop_id;
		logic [31:0] end_id;
		logic [23:0] data_len;
		logic [7:0]  payload_byte;
	} rec_t;

endpackage

@@ rtl/dmp_core.sv @@
`timescale 1ns / 1ps
// dmp_core: per-byte parse state and single-pass record logic
// depends on dmp_pkg

module dmp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               buffer_end,
	output logic               have,
	output dmp_pkg::rec_t      rec
);

	typedef enum logic [2:0] {
		PH_HDR     = 3'd0,
		PH_AVP_HDR = 3'd1,
		PH_DATA    = 3'd2,
		PH_PAD     = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	localparam logic [3:0] IdxFlags    = 4'd4;
	localparam logic [3:0] IdxLenLast  = 4'd7;
	localparam logic [3:0] IdxVendLast = 4'd11;
	localparam logic [23:0] CountMax   = '1;
	localparam logic [23:0] HdrLast    = 24'(dmp_pkg::HdrLen - 1);
	localparam logic [23:0] HdrLenC    = 24'(dmp_pkg::HdrLen);

	phase_t              phase_q, phase_d;
	logic [23:0]         count_q, next_pos;
	logic [7:0]          hdr_q [dmp_pkg::HdrLen-1];
	logic [3:0]          idx_q, idx_d;
	logic [31:0]         code_q, code_d;
	logic [7:0]          flags_q, flags_d;
	logic [23:0]         len_q, len_d;
	logic [31:0]         vendor_q, vendor_d;
	logic [23:0]         drem_q, drem_d;
	logic [1:0]          pad_q, pad_d;
	dmp_pkg::err_code_t  err_q, err_d, ec;

	logic [23:0] ml, room, len_full, len_m8, len_mh;
	logic        ml_gt, has_vendor, hdr_we, go_enter, go_after;

	assign next_pos   = (count_q == CountMax) ? count_q : count_q + 24'd1;
	assign ml         = {hdr_q[1], hdr_q[2], hdr_q[3]};
	assign ml_gt      = ml > next_pos;
	assign room       = ml_gt ? ml - next_pos : 24'd0;
	assign has_vendor = |(flags_q & dmp_pkg::VendorFlag);
	assign len_full   = {len_q[15:0], data_byte};
	assign len_m8     = len_full - dmp_pkg::AvpFixed;
	assign len_mh     = len_full - (has_vendor ? dmp_pkg::AvpVendHdr : dmp_pkg::AvpFixed);
	assign hdr_we     = (phase_q == PH_HDR) && (count_q < HdrLast);

	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		code_d   = code_q;
		flags_d  = flags_q;
		len_d    = len_q;
		vendor_d = vendor_q;
		drem_d   = drem_q;
		pad_d    = pad_q;
		err_d    = err_q;
		ec       = dmp_pkg::ERR_NONE;
		rec      = '0;
		have     = 1'b0;
		go_enter = 1'b0;
		go_after = 1'b0;

		unique case (phase_q)
			PH_HDR: begin
				if (count_q == HdrLast) begin
					if (hdr_q[0] != dmp_pkg::DiamVersion) begin
						phase_d = PH_DONE;
					end else begin
						rec.rec_kind      = dmp_pkg::REC_HEADER;
						rec.msg_length    = ml;
						rec.flag_bits     = hdr_q[4];
						rec.code          = {8'd0, hdr_q[5], hdr_q[6], hdr_q[7]};
						rec.app_or_vendor = {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
						rec.hop_id        = {hdr_q[12], hdr_q[13], hdr_q[14], hdr_q[15]};
						rec.end_id        = {hdr_q[16], hdr_q[17], hdr_q[18], data_byte};
						have              = 1'b1;
						go_enter          = 1'b1;
					end
				end
			end
			PH_AVP_HDR: begin
				idx_d = idx_q + 4'd1;
				if (idx_q < IdxFlags) begin
					code_d = {code_q[23:0], data_byte};
				end else if (idx_q == IdxFlags) begin
					flags_d = data_byte;
				end else if (idx_q <= IdxLenLast) begin
					len_d = {len_q[15:0], data_byte};
				end else begin
					vendor_d = {vendor_q[23:0], data_byte};
				end

				if (idx_q == IdxLenLast) begin
					if (len_full < (has_vendor ? dmp_pkg::AvpVendHdr : dmp_pkg::AvpFixed)) begin
						phase_d = PH_DONE;
						if (err_q == dmp_pkg::ERR_NONE) err_d = dmp_pkg::ERR_AVP_LEN;
					end else if (len_m8 > room) begin
						phase_d = PH_DONE;
						if (err_q == dmp_pkg::ERR_NONE) err_d = dmp_pkg::ERR_DATA_OVR;
					end else begin
						drem_d = len_mh;
						pad_d  = 2'(2'd0 - len_mh[1:0]);
						// without vendor id the avp header is complete here
						if (!has_vendor) begin
							rec.rec_kind  = dmp_pkg::REC_AVP_HDR;
							rec.flag_bits = flags_q;
							rec.code      = code_q;
							rec.data_len  = len_mh;
							have          = 1'b1;
							if (len_mh != 24'd0) phase_d = PH_DATA;
							else go_after = 1'b1;
						end
					end
				end else if (idx_q == IdxVendLast) begin
					rec.rec_kind      = dmp_pkg::REC_AVP_HDR;
					rec.flag_bits     = flags_q;
					rec.code          = code_q;
					rec.app_or_vendor = vendor_d;
					rec.data_len      = drem_q;
					have              = 1'b1;
					if (drem_q != 24'd0) phase_d = PH_DATA;
					else go_after = 1'b1;
				end
			end
			PH_DATA: begin
				rec.rec_kind     = dmp_pkg::REC_DATA;
				rec.payload_byte = data_byte;
				have             = 1'b1;
				drem_d           = drem_q - 24'd1;
				if (drem_d == 24'd0) go_after = 1'b1;
			end
			PH_PAD: begin
				pad_d = pad_q - 2'd1;
				if (pad_d == 2'd0) go_enter = 1'b1;
			end
			default: begin
			end
		endcase

		if (go_after) begin
			if (pad_d != 2'd0) phase_d = PH_PAD;
			else go_enter = 1'b1;
		end

		// next avp starts at next_pos, or the message is done
		if (go_enter) begin
			if (!ml_gt) begin
				phase_d = PH_DONE;
			end else if (room < dmp_pkg::AvpFixed) begin
				phase_d = PH_DONE;
				if (err_d == dmp_pkg::ERR_NONE) err_d = dmp_pkg::ERR_AVP_HDR;
			end else begin
				phase_d  = PH_AVP_HDR;
				idx_d    = '0;
				code_d   = '0;
				flags_d  = '0;
				len_d    = '0;
				vendor_d = '0;
			end
		end

		if (buffer_end) begin
			priority if (next_pos < HdrLenC) ec = dmp_pkg::ERR_SHORT_HDR;
			else if (hdr_q[0] != dmp_pkg::DiamVersion) ec = dmp_pkg::ERR_VERSION;
			else if (ml_gt) ec = dmp_pkg::ERR_SHORT_MSG;
			else ec = err_d;

			if (ec != dmp_pkg::ERR_NONE) begin
				rec            = '0;
				rec.rec_kind   = dmp_pkg::REC_ERROR;
				rec.error_code = ec;
			end else begin
				rec.rec_kind   = dmp_pkg::REC_END;
				rec.error_code = dmp_pkg::ERR_NONE;
			end
			have     = 1'b1;
			phase_d  = PH_HDR;
			idx_d    = '0;
			code_d   = '0;
			flags_d  = '0;
			len_d    = '0;
			vendor_d = '0;
			drem_d   = '0;
			pad_d    = '0;
			err_d    = dmp_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			count_q  <= '0;
			idx_q    <= '0;
			code_q   <= '0;
			flags_q  <= '0;
			len_q    <= '0;
			vendor_q <= '0;
			drem_q   <= '0;
			pad_q    <= '0;
			err_q    <= dmp_pkg::ERR_NONE;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= buffer_end ? '0 : next_pos;
			idx_q    <= idx_d;
			code_q   <= code_d;
			flags_q  <= flags_d;
			len_q    <= len_d;
			vendor_q <= vendor_d;
			drem_q   <= drem_d;
			pad_q    <= pad_d;
			err_q    <= err_d;
		end
	end

	// header bytes, the last one is used straight from the input
	always_ff @(posedge clk) begin
		if (step && hdr_we) begin
			hdr_q[count_q[4:0]] <= data_byte;
		end
	end

endmodule

@@ rtl/diameter_message_parser.sv @@
`timescale 1ns / 1ps
// diameter_message_parser: top level, stream handshakes around dmp_core
// depends on dmp_pkg and dmp_core
//
// an accepted input byte is held in the input register, and its record in the result register
// throughput: one byte per cycle while the output is not stalled, set by the single-pass parse logic
// a byte with no record (header bytes, padding, ignored bytes) is absorbed
// reset: arst_n clears both stage valids and all parse state but the stored header bytes, header phase

module diameter_message_parser (
	input  logic           clk,
	input  logic           arst_n,
	// input items
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [7:0]     s_axis_tdata,   // [7:0] data_byte
	input  logic           s_axis_tlast,   // buffer_end
	// result items
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [199:0]   m_axis_tdata,   // error_code, msg_length, flag_bits, code,
	                                       // app_or_vendor, hop_id, end_id, data_len,
	                                       // payload_byte, zero fill
	output logic [2:0]     m_axis_tuser    // rec_kind
);

	// input register
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	// result register
	logic          valid_s2;
	dmp_pkg::rec_t rec_s2;

	logic          advance;
	logic          step;
	logic          have;
	dmp_pkg::rec_t rec;

	// the result register can take a new record when empty or being drained
	assign advance       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && advance;
	// input register frees up when its item moves on, or is empty
	assign s_axis_tready = advance || !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (advance) valid_s2 <= step && have;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (step && have) begin
			rec_s2 <= rec;
		end
	end

	// parse state and record building
	dmp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.buffer_end (last_s1),
		.have       (have),
		.rec        (rec)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = rec_s2.rec_kind;
	assign m_axis_tdata  = {5'd0,
	                        rec_s2.payload_byte,
	                        rec_s2.data_len,
	                        rec_s2.end_id,
	                        rec_s2.hop_id,
	                        rec_s2.app_or_vendor,
	                        rec_s2.code,
	                        rec_s2.flag_bits,
	                        rec_s2.msg_length,
	                        rec_s2.error_code};

endmodule

@@ tb/tb_diameter_message_parser.sv @@
`timescale 1ns / 1ps
// tb_diameter_message_parser: self-checking bench for the byte-serial diameter parser
// builds diameter buffers byte by byte, predicts every record and compares; needs dmp_pkg

module tb_diameter_message_parser;

	localparam int unsigned QuietLimit  = 3000;  // cycles with no item moving on either side
	localparam int unsigned RandomBytes = 510;
	localparam int unsigned DrainCycles = 8;     // margin past the result register, with room for a stray record

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_AVP_HEADER,
		PH_DATA,
		PH_PAD,
		PH_DONE
	} parse_phase_t;

	// kinds of damage applied to a generated buffer
	typedef enum int {
		FAULT_NONE,
		FAULT_SHORT_HDR,
		FAULT_VERSION,
		FAULT_SHORT_MSG,
		FAULT_AVP_HDR,
		FAULT_AVP_LEN,
		FAULT_DATA_OVR,
		FAULT_NOISE
	} frame_fault_t;

	// mirrors the parse state and holds the records still to come out of the block
	class dmp_record_board;
		parse_phase_t        phase;
		logic [23:0]         byte_count;
		logic [7:0]          hdr_bytes [dmp_pkg::HdrLen];
		logic [3:0]          avp_idx;
		logic [31:0]         cur_code;
		logic [7:0]          cur_flags;
		logic [23:0]         avp_len;
		logic [31:0]         avp_vendor;
		logic [23:0]         data_left;
		logic [1:0]          pad_left;
		dmp_pkg::err_code_t  avp_err;
		dmp_pkg::rec_t       expected_records [$];
		int unsigned         errors;
		int unsigned         n_checked;

		function new();
			errors = 0;
			n_checked = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_HEADER;
			byte_count = '0;
			foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
			avp_idx = '0;
			cur_code = '0;
			cur_flags = '0;
			avp_len = '0;
			avp_vendor = '0;
			data_left = '0;
			pad_left = '0;
			avp_err = dmp_pkg::ERR_NONE;
		endfunction

		function int unsigned pending();
			return expected_records.size();
		endfunction

		task report(input string what);
			errors++;
			$display("mismatch at %0t: %s", $realtime, what);
		endtask

		// big-endian value from the stored header bytes
		function logic [31:0] hdr_field(input int unsigned first, input int unsigned count);
			logic [31:0] v;
			v = '0;
			for (int unsigned i = 0; i < count; i++)
				v = {v[23:0], hdr_bytes[(first + i) % dmp_pkg::HdrLen]};
			return v;
		endfunction

		function logic [23:0] msg_len();
			return hdr_field(1, 3);
		endfunction

		function void latch_err(input dmp_pkg::err_code_t e);
			if (avp_err == dmp_pkg::ERR_NONE)
				avp_err = e;
			phase = PH_DONE;
		endfunction

		function void enter_avp(input logic [23:0] next_pos);
			logic [23:0] ml;
			ml = msg_len();
			if (next_pos >= ml) begin
				phase = PH_DONE;
			end else if (ml - next_pos < dmp_pkg::AvpFixed) begin
				latch_err(dmp_pkg::ERR_AVP_HDR);
			end else begin
				phase = PH_AVP_HEADER;
				avp_idx = '0;
				cur_code = '0;
				cur_flags = '0;
				avp_len = '0;
				avp_vendor = '0;
			end
		endfunction

		function void after_data(input logic [23:0] next_pos);
			if (pad_left != 0)
				phase = PH_PAD;
			else
				enter_avp(next_pos);
		endfunction

		// one accepted byte: advance the parse and queue the record it causes
		function void take_byte(input logic [7:0] b, input logic last);
			logic [23:0]         pos, nxt, ml, room, hsz;
			logic [3:0]          k;
			dmp_pkg::rec_t       r;
			bit                  have, emit;
			dmp_pkg::err_code_t  ec;
			pos = byte_count;
			nxt = (pos != 24'hFFFFFF) ? pos + 24'd1 : pos;
			byte_count = nxt;
			r = '0;
			have = 0;
			emit = 0;
			case (phase)
				PH_HEADER: begin
					hdr_bytes[pos % dmp_pkg::HdrLen] = b;
					if (pos >= dmp_pkg::HdrLen - 1) begin
						if (hdr_bytes[0] != dmp_pkg::DiamVersion) begin
							phase = PH_DONE;
						end else begin
							r.rec_kind = dmp_pkg::REC_HEADER;
							r.msg_length = msg_len();
							r.flag_bits = hdr_bytes[4];
							r.code = hdr_field(5, 3);
							r.app_or_vendor = hdr_field(8, 4);
							r.hop_id = hdr_field(12, 4);
							r.end_id = hdr_field(16, 4);
							have = 1;
							enter_avp(24'(dmp_pkg::HdrLen));
						end
					end
				end
				PH_AVP_HEADER: begin
					k = avp_idx;
					if (k < 4)
						cur_code = {cur_code[23:0], b};
					else if (k == 4)
						cur_flags = b;
					else if (k < 8)
						avp_len = {avp_len[15:0], b};
					else
						avp_vendor = {avp_vendor[23:0], b};
					avp_idx = k + 4'd1;
					if (k == 4'd7) begin
						hsz = cur_flags[7] ? dmp_pkg::AvpVendHdr : dmp_pkg::AvpFixed;
						ml = msg_len();
						room = (ml > nxt) ? ml - nxt : 24'd0;
						if (avp_len < hsz) begin
							latch_err(dmp_pkg::ERR_AVP_LEN);
						end else if (avp_len - dmp_pkg::AvpFixed > room) begin
							latch_err(dmp_pkg::ERR_DATA_OVR);
						end else begin
							data_left = avp_len - hsz;
							pad_left = 2'd0 - data_left[1:0];
							emit = (hsz == dmp_pkg::AvpFixed);
						end
					end else if (k == 4'd11) begin
						emit = 1;
					end
					if (emit) begin
						r.rec_kind = dmp_pkg::REC_AVP_HDR;
						r.flag_bits = cur_flags;
						r.code = cur_code;
						r.app_or_vendor = avp_vendor;
						r.data_len = data_left;
						have = 1;
						if (data_left != 0)
							phase = PH_DATA;
						else
							after_data(nxt);
					end
				end
				PH_DATA: begin
					r.rec_kind = dmp_pkg::REC_DATA;
					r.payload_byte = b;
					have = 1;
					data_left = data_left - 24'd1;
					if (data_left == 0)
						after_data(nxt);
				end
				PH_PAD: begin
					pad_left = pad_left - 2'd1;
					if (pad_left == 0)
						enter_avp(nxt);
				end
				default: ;
			endcase

			// end of buffer: an error record replaces whatever this byte gave; an end record keeps its other fields
			if (last) begin
				if (nxt < 24'(dmp_pkg::HdrLen))
					ec = dmp_pkg::ERR_SHORT_HDR;
				else if (hdr_bytes[0] != dmp_pkg::DiamVersion)
					ec = dmp_pkg::ERR_VERSION;
				else if (msg_len() > nxt)
					ec = dmp_pkg::ERR_SHORT_MSG;
				else
					ec = avp_err;
				if (ec != dmp_pkg::ERR_NONE) begin
					r = '0;
					r.rec_kind = dmp_pkg::REC_ERROR;
					r.error_code = ec;
				end else begin
					r.rec_kind = dmp_pkg::REC_END;
					r.error_code = dmp_pkg::ERR_NONE;
				end
				have = 1;
				clear();
			end
			if (have)
				expected_records.push_back(r);
		endfunction

		function string field_diff(input string name, input logic [31:0] g,
				input logic [31:0] w);
			return (g !== w) ? $sformatf(" %s %0h/%0h", name, g, w) : "";
		endfunction

		// one accepted result against the oldest expected record
		task check_record(input logic [199:0] data, input logic [2:0] kind);
			dmp_pkg::rec_t  got, want;
			string          diff;
			n_checked++;
			if (expected_records.size() == 0) begin
				report($sformatf("record %0d of kind %0d with nothing expected",
					n_checked, kind));
			end else begin
				want = expected_records.pop_front();
				got.rec_kind = dmp_pkg::rec_kind_t'(kind);
				got.error_code = dmp_pkg::err_code_t'(data[2:0]);
				got.msg_length = data[26:3];
				got.flag_bits = data[34:27];
				got.code = data[66:35];
				got.app_or_vendor = data[98:67];
				got.hop_id = data[130:99];
				got.end_id = data[162:131];
				got.data_len = data[186:163];
				got.payload_byte = data[194:187];
				diff = {field_diff("rec_kind", got.rec_kind, want.rec_kind),
					field_diff("error_code", got.error_code, want.error_code),
					field_diff("msg_length", got.msg_length, want.msg_length),
					field_diff("flag_bits", got.flag_bits, want.flag_bits),
					field_diff("code", got.code, want.code),
					field_diff("app_or_vendor", got.app_or_vendor, want.app_or_vendor),
					field_diff("hop_id", got.hop_id, want.hop_id),
					field_diff("end_id", got.end_id, want.end_id),
					field_diff("data_len", got.data_len, want.data_len),
					field_diff("payload_byte", got.payload_byte, want.payload_byte)};
				if (diff != "")
					report($sformatf("record %0d (got/expected):%s", n_checked, diff));
			end
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;   // [7:0] data_byte
	logic         s_axis_tlast;   // buffer_end
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [199:0] m_axis_tdata;   // error_code, msg_length, flag_bits, code, app_or_vendor,
	                              // hop_id, end_id, data_len, payload_byte, zero fill
	logic [2:0]   m_axis_tuser;   // rec_kind

	dmp_record_board board;
	logic [7:0]      frame_q [$];   // the buffer being built, first byte at the front
	bit              calm;          // no idling on either side while set
	int unsigned     random_sent;
	int unsigned     quiet;

	diameter_message_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	// result side stalls with a 38 percent chance, never while calm
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 38);
	end

	// monitors: inputs are noted before results so a record that came out with its own input would still match
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.take_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				board.check_record(m_axis_tdata, m_axis_tuser);
		end
	end

	// watchdog on cycles where no item moves on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QuietLimit) begin
				$display("** diameter_message_parser: FAILED **");
				$finish;
			end
		end
	end

	// one byte onto the input stream, with random idle cycles ahead of it
	task automatic drive_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(0, 99) < 38) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			drive_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	// 20 header bytes with a zero length; fill below zero means random content
	task automatic push_header(input logic [7:0] ver, input int fill);
		frame_q.push_back(ver);
		repeat (3) frame_q.push_back(8'h00);
		repeat (16) frame_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
	endtask

	task automatic set_len(input logic [23:0] ml);
		frame_q[1] = ml[23:16];
		frame_q[2] = ml[15:8];
		frame_q[3] = ml[7:0];
	endtask

	// avp header as given, then vendor id if flagged, data bytes and padding
	task automatic push_avp(input logic [31:0] code_word, input logic [7:0] flags,
			input logic [23:0] alen, input int unsigned dlen);
		for (int i = 3; i >= 0; i--)
			frame_q.push_back(code_word[8*i +: 8]);
		frame_q.push_back(flags);
		for (int i = 2; i >= 0; i--)
			frame_q.push_back(alen[8*i +: 8]);
		if (flags & dmp_pkg::VendorFlag)
			repeat (4) frame_q.push_back(8'($urandom));
		repeat (dlen) frame_q.push_back(8'($urandom));
		repeat ((4 - dlen % 4) % 4) frame_q.push_back(8'($urandom));
	endtask

	task automatic build_random_frame(input frame_fault_t fault);
		logic [7:0]  ver, flags;
		logic [23:0] alen, hsz;
		int unsigned n_avp, bad_idx, ml, last_pad, dlen, cut;
		frame_q.delete();
		if (fault == FAULT_NOISE) begin
			repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
			return;
		end
		ver = dmp_pkg::DiamVersion;
		if (fault == FAULT_VERSION) begin
			ver = 8'($urandom);
			if (ver == dmp_pkg::DiamVersion)
				ver = 8'h00;
		end
		push_header(ver, -1);
		n_avp = $urandom_range(0, 3);
		if (fault inside {FAULT_AVP_LEN, FAULT_DATA_OVR}) begin
			if (n_avp == 0)
				n_avp = 1;
			bad_idx = $urandom_range(0, n_avp - 1);
		end else begin
			bad_idx = n_avp;
		end
		last_pad = 0;
		for (int unsigned i = 0; i < n_avp; i++) begin
			flags = 8'($urandom);
			hsz = flags[7] ? dmp_pkg::AvpVendHdr : dmp_pkg::AvpFixed;
			// mostly short data, now and then a longer run
			dlen = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 9) : $urandom_range(10, 40);
			alen = hsz + 24'(dlen);
			if (i == bad_idx && fault == FAULT_AVP_LEN)
				alen = 24'($urandom_range(0, hsz - 1));
			if (i == bad_idx && fault == FAULT_DATA_OVR)
				alen = 24'($urandom_range(300, 24'hFFFFFF));
			push_avp($urandom, flags, alen, dlen);
			last_pad = (4 - dlen % 4) % 4;
		end
		ml = frame_q.size();
		if (fault == FAULT_AVP_HDR) begin
			// fewer than 8 bytes left inside the message for the next avp header
			cut = $urandom_range(1, 7);
			repeat (cut) frame_q.push_back(8'($urandom));
			ml += cut;
		end else if (last_pad != 0 && $urandom_range(0, 1)) begin
			// final padding lies beyond the message length
			ml -= last_pad;
		end
		if (fault == FAULT_SHORT_MSG)
			ml += $urandom_range(1, 40);
		set_len(24'(ml));
		if (fault == FAULT_SHORT_HDR) begin
			cut = $urandom_range(1, dmp_pkg::HdrLen - 1);
			while (frame_q.size() > cut)
				void'(frame_q.pop_back());
		end else if ($urandom_range(0, 3) == 0) begin
			// trailing bytes past the message are ignored
			repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
		end
	endtask

	initial begin
		frame_fault_t fault;
		int unsigned  pick, n_frames;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		calm = 1'b0;
		random_sent = 0;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone byte of all ones: short header
		frame_q = {8'hFF};
		send_frame();
		// header only, buffer ends on the byte that completes it, fields all ones
		frame_q.delete();
		push_header(dmp_pkg::DiamVersion, 255);
		set_len(24'd20);
		send_frame();
		// zero message length, then bytes that are ignored
		frame_q.delete();
		push_header(dmp_pkg::DiamVersion, 0);
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'h00);
		send_frame();
		// wrong version
		frame_q.delete();
		push_header(8'h00, -1);
		frame_q.push_back(8'h5A);
		set_len(24'd21);
		send_frame();
		// vendor id runs past the message end: data overrun
		frame_q.delete();
		push_header(dmp_pkg::DiamVersion, -1);
		push_avp(32'hFFFF_FFFF, dmp_pkg::VendorFlag, 24'd12, 0);
		set_len(24'd28);
		send_frame();
		// avp length below its header size
		frame_q.delete();
		push_header(dmp_pkg::DiamVersion, -1);
		push_avp(32'h0, 8'h00, 24'd5, 0);
		set_len(24'd28);
		send_frame();
		// only 7 bytes left for an avp header
		frame_q.delete();
		push_header(dmp_pkg::DiamVersion, -1);
		repeat (7) frame_q.push_back(8'($urandom));
		set_len(24'd27);
		send_frame();
		// message length beyond the buffer, buffer ends inside avp data
		frame_q.delete();
		push_header(dmp_pkg::DiamVersion, -1);
		push_avp($urandom, 8'h00, 24'd12, 4);
		void'(frame_q.pop_back());
		void'(frame_q.pop_back());
		set_len(24'd100);
		send_frame();
		// well formed: empty avp, vendor avp with padding, buffer ends on a data byte
		frame_q.delete();
		push_header(dmp_pkg::DiamVersion, -1);
		push_avp(32'h0, 8'h00, 24'd8, 0);
		push_avp(32'hFFFF_FFFF, 8'hFF, 24'd15, 3);
		push_avp($urandom, 8'h7F, 24'd12, 4);
		set_len(24'(frame_q.size()));
		send_frame();

		// random buffers, mostly well formed, with a stretch free of idling
		n_frames = 0;
		while (random_sent < RandomBytes) begin
			calm <= (n_frames >= 5 && n_frames < 9);
			pick = $urandom_range(0, 99);
			if (pick < 65)
				fault = FAULT_NONE;
			else if (pick < 70)
				fault = FAULT_SHORT_HDR;
			else if (pick < 75)
				fault = FAULT_VERSION;
			else if (pick < 80)
				fault = FAULT_SHORT_MSG;
			else if (pick < 85)
				fault = FAULT_AVP_HDR;
			else if (pick < 90)
				fault = FAULT_AVP_LEN;
			else if (pick < 95)
				fault = FAULT_DATA_OVR;
			else
				fault = FAULT_NOISE;
			build_random_frame(fault);
			send_frame();
			random_sent += frame_q.size();
			n_frames++;
		end
		s_axis_tvalid <= 1'b0;
		calm <= 1'b0;

		// drain, then allow a stray record to show up
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (board.errors == 0)
			$display("** diameter_message_parser: PASSED **");
		else
			$display("** diameter_message_parser: FAILED **");
		$finish;
	end

endmodule
